FILE: rtl/ubx_config_reply_field_extractor_unit_assert.svh
// ----------------------------------------------------------------------------
// UBX reply extractor assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef UBX_CONFIG_REPLY_FIELD_EXTRACTOR_UNIT_ASSERT_SVH
`define UBX_CONFIG_REPLY_FIELD_EXTRACTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define UBXCFG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UBXCFG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ubxcfg_pkg.sv
// ----------------------------------------------------------------------------
// UBX reply extractor package
// Beat types, codes and constants shared by the extractor modules.
// ----------------------------------------------------------------------------
package ubxcfg_pkg;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_FOUND   = 2'd1,
		EV_TIMEOUT = 2'd2
	} event_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_HUNT  = 2'd1,
		PH_SYNC2 = 2'd2,
		PH_FRAME = 2'd3
	} phase_t;

	localparam logic [1:0] REG_TIMEOUT_MS     = 2'd0;
	localparam logic [1:0] REG_WANTED_CLASS   = 2'd1;
	localparam logic [1:0] REG_WANTED_ID      = 2'd2;
	localparam logic [1:0] REG_CAPTURE_OFFSET = 2'd3;

	localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
	localparam logic [7:0]  CLASS_RESET   = 8'h06;
	localparam logic [7:0]  ID_RESET      = 8'h24;
	localparam logic [5:0]  OFFSET_RESET  = 6'd8;

	localparam logic [7:0]  SYNC_FIRST    = 8'hB5;
	localparam logic [7:0]  SYNC_SECOND   = 8'h62;
	localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;
	localparam logic [16:0] HEADER_BYTES  = 17'd8;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] rx_byte;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic [7:0] dyn_model;
	} out_beat_t;

	typedef struct packed {
		logic [15:0] timeout_ms;
		logic [7:0]  wanted_class;
		logic [7:0]  wanted_id;
		logic [5:0]  capture_offset;
	} cfg_t;

endpackage

FILE: rtl/ubxcfg_tracker.sv
// ----------------------------------------------------------------------------
// UBX reply frame tracker
// Search state and combinational evaluation of one beat; state moves on advance.
// ----------------------------------------------------------------------------
module ubxcfg_tracker #(
	parameter int FRAME_CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  ubxcfg_pkg::in_beat_t item,
	input  ubxcfg_pkg::cfg_t    cfg,
	output ubxcfg_pkg::out_beat_t result
);

	localparam int CW = $clog2(FRAME_CAPACITY + 1);
	localparam logic [CW-1:0] CAPACITY = CW'(FRAME_CAPACITY);
	localparam logic [CW-1:0] SYNC_COUNT = CW'(2);

	ubxcfg_pkg::phase_t phase_q, phase_n;
	logic [CW-1:0] byte_count_q, byte_count_n;
	logic [7:0]    seen_class_q, seen_class_n;
	logic [7:0]    seen_id_q, seen_id_n;
	logic [15:0]   payload_length_q, payload_length_n;
	logic [7:0]    captured_byte_q, captured_byte_n;
	logic [15:0]   elapsed_q, elapsed_n;

	logic          room;
	logic [CW-1:0] fr_count;
	logic [7:0]    fr_class;
	logic [7:0]    fr_id;
	logic [15:0]   fr_length;
	logic [7:0]    fr_captured;
	logic          frame_done;
	logic [15:0]   tick_elapsed;
	logic          expired;
	logic          is_byte;
	logic          is_tick;
	logic [7:0]    b;

	assign b       = item.rx_byte;
	assign is_byte = (item.operation == ubxcfg_pkg::OP_BYTE) && (phase_q != ubxcfg_pkg::PH_IDLE);
	assign is_tick = (item.operation == ubxcfg_pkg::OP_TICK) && (phase_q != ubxcfg_pkg::PH_IDLE);

	// frame byte evaluation
	always_comb begin
		room        = byte_count_q < CAPACITY;
		fr_count    = byte_count_q + CW'(1);
		fr_class    = (byte_count_q == CW'(2)) ? b : seen_class_q;
		fr_id       = (byte_count_q == CW'(3)) ? b : seen_id_q;
		fr_length   = payload_length_q;
		if (byte_count_q == CW'(4)) begin
			fr_length[7:0] = b;
		end
		if (byte_count_q == CW'(5)) begin
			fr_length[15:8] = b;
		end
		fr_captured = (17'(byte_count_q) == 17'(cfg.capture_offset)) ? b : captured_byte_q;
		frame_done  = room
			&& (17'(fr_count) >= ubxcfg_pkg::HEADER_BYTES)
			&& (17'(fr_count) > 17'(cfg.capture_offset))
			&& (fr_class == cfg.wanted_class)
			&& (fr_id == cfg.wanted_id)
			&& (17'(fr_count) >= 17'(fr_length) + ubxcfg_pkg::HEADER_BYTES);
		tick_elapsed = (elapsed_q != ubxcfg_pkg::ELAPSED_MAX) ? elapsed_q + 16'd1 : elapsed_q;
		expired      = tick_elapsed >= cfg.timeout_ms;
	end

	// next state
	always_comb begin
		phase_n          = phase_q;
		byte_count_n     = byte_count_q;
		seen_class_n     = seen_class_q;
		seen_id_n        = seen_id_q;
		payload_length_n = payload_length_q;
		captured_byte_n  = captured_byte_q;
		elapsed_n        = elapsed_q;
		if (item.operation == ubxcfg_pkg::OP_START) begin
			phase_n          = ubxcfg_pkg::PH_HUNT;
			byte_count_n     = '0;
			seen_class_n     = '0;
			seen_id_n        = '0;
			payload_length_n = '0;
			captured_byte_n  = '0;
			elapsed_n        = '0;
		end else if (is_byte) begin
			unique case (phase_q)
				ubxcfg_pkg::PH_HUNT: begin
					if (b == ubxcfg_pkg::SYNC_FIRST) begin
						phase_n = ubxcfg_pkg::PH_SYNC2;
						if (cfg.capture_offset == 6'd0) begin
							captured_byte_n = ubxcfg_pkg::SYNC_FIRST;
						end
					end
				end
				ubxcfg_pkg::PH_SYNC2: begin
					if (b == ubxcfg_pkg::SYNC_SECOND) begin
						phase_n      = ubxcfg_pkg::PH_FRAME;
						byte_count_n = SYNC_COUNT;
						if (cfg.capture_offset == 6'd1) begin
							captured_byte_n = ubxcfg_pkg::SYNC_SECOND;
						end
					end else begin
						phase_n = ubxcfg_pkg::PH_HUNT;
					end
				end
				ubxcfg_pkg::PH_FRAME: begin
					if (frame_done) begin
						phase_n          = ubxcfg_pkg::PH_IDLE;
						byte_count_n     = '0;
						seen_class_n     = '0;
						seen_id_n        = '0;
						payload_length_n = '0;
						captured_byte_n  = '0;
						elapsed_n        = '0;
					end else if (room) begin
						byte_count_n     = fr_count;
						seen_class_n     = fr_class;
						seen_id_n        = fr_id;
						payload_length_n = fr_length;
						captured_byte_n  = fr_captured;
					end
				end
				default: begin
					phase_n = phase_q;
				end
			endcase
		end else if (is_tick) begin
			if (expired) begin
				phase_n          = ubxcfg_pkg::PH_IDLE;
				byte_count_n     = '0;
				seen_class_n     = '0;
				seen_id_n        = '0;
				payload_length_n = '0;
				captured_byte_n  = '0;
				elapsed_n        = '0;
			end else begin
				elapsed_n = tick_elapsed;
			end
		end
	end

	// result
	always_comb begin
		result.event_res = ubxcfg_pkg::EV_NONE;
		result.dyn_model = '0;
		if (is_byte && (phase_q == ubxcfg_pkg::PH_FRAME) && frame_done) begin
			result.event_res = ubxcfg_pkg::EV_FOUND;
			result.dyn_model = fr_captured;
		end else if (is_tick && expired) begin
			result.event_res = ubxcfg_pkg::EV_TIMEOUT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= ubxcfg_pkg::PH_IDLE;
			byte_count_q     <= '0;
			seen_class_q     <= '0;
			seen_id_q        <= '0;
			payload_length_q <= '0;
			captured_byte_q  <= '0;
			elapsed_q        <= '0;
		end else if (advance) begin
			phase_q          <= phase_n;
			byte_count_q     <= byte_count_n;
			seen_class_q     <= seen_class_n;
			seen_id_q        <= seen_id_n;
			payload_length_q <= payload_length_n;
			captured_byte_q  <= captured_byte_n;
			elapsed_q        <= elapsed_n;
		end
	end

`include "ubx_config_reply_field_extractor_unit_assert.svh"

	`UBXCFG_ASSERT_NEXT(a_report_idles, advance && (result.event_res != ubxcfg_pkg::EV_NONE), phase_q == ubxcfg_pkg::PH_IDLE, "search not closed after report")
	`UBXCFG_ASSERT_NOW(a_idle_clear, phase_q == ubxcfg_pkg::PH_IDLE, (byte_count_q == '0) && (elapsed_q == '0), "idle with stale search state")
	`UBXCFG_ASSERT_NOW(a_count_bound, 1'b1, byte_count_q <= CAPACITY, "byte count beyond frame capacity")
	`UBXCFG_ASSERT_NEXT(a_hold, !advance, $stable(phase_q) && $stable(byte_count_q) && $stable(elapsed_q), "state moved without advance")

endmodule

FILE: rtl/ubx_config_reply_field_extractor_unit.sv
// ----------------------------------------------------------------------------
// UBX configuration reply field extractor
// Finds a UBX frame of the wanted class and id and reports one payload byte.
// ----------------------------------------------------------------------------
// Each input beat (start, received byte or millisecond tick) yields exactly one
// result beat. A beat is held in an input register, evaluated against the
// search state combinationally, and its result lands in an output register;
// one beat per cycle is sustained while out_stall is low, since the tracker
// updates its state on every advance. Configuration is written through
// cfg_we/cfg_index/cfg_data.
module ubx_config_reply_field_extractor_unit #(
	parameter int FRAME_CAPACITY = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ubxcfg_pkg::in_beat_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ubxcfg_pkg::out_beat_t out_data,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data
);

	ubxcfg_pkg::cfg_t      cfg_q;
	ubxcfg_pkg::in_beat_t  item_s1;
	logic                  valid_s1;
	ubxcfg_pkg::out_beat_t result;
	ubxcfg_pkg::out_beat_t data_s2;
	logic                  valid_s2;
	logic                  advance;

	assign advance   = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms     <= ubxcfg_pkg::TIMEOUT_RESET;
			cfg_q.wanted_class   <= ubxcfg_pkg::CLASS_RESET;
			cfg_q.wanted_id      <= ubxcfg_pkg::ID_RESET;
			cfg_q.capture_offset <= ubxcfg_pkg::OFFSET_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ubxcfg_pkg::REG_TIMEOUT_MS:     cfg_q.timeout_ms     <= cfg_data;
				ubxcfg_pkg::REG_WANTED_CLASS:   cfg_q.wanted_class   <= cfg_data[7:0];
				ubxcfg_pkg::REG_WANTED_ID:      cfg_q.wanted_id      <= cfg_data[7:0];
				ubxcfg_pkg::REG_CAPTURE_OFFSET: cfg_q.capture_offset <= cfg_data[5:0];
			endcase
		end
	end

	// input stage: load on accept, drop when moved on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	ubxcfg_tracker #(
		.FRAME_CAPACITY(FRAME_CAPACITY)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	// result stage: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= result;
		end
	end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// UBX reply extractor testbench
// Drives start, byte, tick and reserved beats with random gaps and output stalls.
// A tracker follows the frame search beat by beat and predicts every report,
// which is checked in order against the result beats of the unit.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int FRAME_BYTES = 64;
	localparam int HALF_PERIOD = 6;
	localparam int RANDOM_ITEMS = 700;
	localparam int RUN_LIMIT_CYCLES = 700000;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	class ubx_report_tracker;
		logic [15:0] timeout_ms;
		logic [7:0]  wanted_class;
		logic [7:0]  wanted_id;
		logic [5:0]  capture_offset;
		ubxcfg_pkg::phase_t phase;
		logic [6:0]  byte_count;
		logic [7:0]  seen_class;
		logic [7:0]  seen_id;
		logic [15:0] payload_length;
		logic [7:0]  captured_byte;
		logic [15:0] elapsed_ms;
		ubxcfg_pkg::out_beat_t pending_reports[$];
		int          errors;

		function new();
			timeout_ms = ubxcfg_pkg::TIMEOUT_RESET;
			wanted_class = ubxcfg_pkg::CLASS_RESET;
			wanted_id = ubxcfg_pkg::ID_RESET;
			capture_offset = ubxcfg_pkg::OFFSET_RESET;
			errors = 0;
			clear_search();
		endfunction

		function void clear_search();
			phase = ubxcfg_pkg::PH_IDLE;
			byte_count = '0;
			seen_class = '0;
			seen_id = '0;
			payload_length = '0;
			captured_byte = '0;
			elapsed_ms = '0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] value);
			case (idx)
				ubxcfg_pkg::REG_TIMEOUT_MS:     timeout_ms = value;
				ubxcfg_pkg::REG_WANTED_CLASS:   wanted_class = value[7:0];
				ubxcfg_pkg::REG_WANTED_ID:      wanted_id = value[7:0];
				ubxcfg_pkg::REG_CAPTURE_OFFSET: capture_offset = value[5:0];
				default: ;
			endcase
		endfunction

		function void note_beat(ubxcfg_pkg::in_beat_t b);
			ubxcfg_pkg::out_beat_t r;
			r = '0;
			r.event_res = ubxcfg_pkg::EV_NONE;
			case (b.operation)
				ubxcfg_pkg::OP_START: begin
					clear_search();
					phase = ubxcfg_pkg::PH_HUNT;
				end
				ubxcfg_pkg::OP_BYTE: begin
					case (phase)
						ubxcfg_pkg::PH_HUNT: begin
							if (b.rx_byte == ubxcfg_pkg::SYNC_FIRST) begin
								phase = ubxcfg_pkg::PH_SYNC2;
								if (capture_offset == 0)
									captured_byte = ubxcfg_pkg::SYNC_FIRST;
							end
						end
						ubxcfg_pkg::PH_SYNC2: begin
							if (b.rx_byte == ubxcfg_pkg::SYNC_SECOND) begin
								phase = ubxcfg_pkg::PH_FRAME;
								byte_count = 7'd2;
								if (capture_offset == 1)
									captured_byte = ubxcfg_pkg::SYNC_SECOND;
							end else begin
								phase = ubxcfg_pkg::PH_HUNT;
							end
						end
						ubxcfg_pkg::PH_FRAME: begin
							if (int'(byte_count) < FRAME_BYTES) begin
								case (byte_count)
									7'd2: seen_class = b.rx_byte;
									7'd3: seen_id = b.rx_byte;
									7'd4: payload_length[7:0] = b.rx_byte;
									7'd5: payload_length[15:8] = b.rx_byte;
									default: ;
								endcase
								if (byte_count == capture_offset)
									captured_byte = b.rx_byte;
								byte_count = byte_count + 7'd1;
								if (int'(byte_count) >= int'(ubxcfg_pkg::HEADER_BYTES) &&
										byte_count > capture_offset &&
										seen_class == wanted_class &&
										seen_id == wanted_id &&
										int'(byte_count) >= int'(payload_length) +
										int'(ubxcfg_pkg::HEADER_BYTES)) begin
									r.event_res = ubxcfg_pkg::EV_FOUND;
									r.dyn_model = captured_byte;
									clear_search();
								end
							end
						end
						default: ;
					endcase
				end
				ubxcfg_pkg::OP_TICK: begin
					if (phase != ubxcfg_pkg::PH_IDLE) begin
						if (elapsed_ms < ubxcfg_pkg::ELAPSED_MAX)
							elapsed_ms = elapsed_ms + 16'd1;
						if (elapsed_ms >= timeout_ms) begin
							r.event_res = ubxcfg_pkg::EV_TIMEOUT;
							clear_search();
						end
					end
				end
				default: ;
			endcase
			pending_reports.push_back(r);
		endfunction

		function void check_report(ubxcfg_pkg::out_beat_t got);
			ubxcfg_pkg::out_beat_t want;
			if (pending_reports.size() == 0) begin
				$display("%0t: report with none pending, event %0d mode %0h",
					$time, got.event_res, got.dyn_model);
				errors++;
				return;
			end
			want = pending_reports.pop_front();
			if (got.event_res !== want.event_res) begin
				$display("%0t: event_res expected %0d, got %0d",
					$time, want.event_res, got.event_res);
				errors++;
			end
			if (got.dyn_model !== want.dyn_model) begin
				$display("%0t: dyn_model expected %0h, got %0h",
					$time, want.dyn_model, got.dyn_model);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	ubxcfg_pkg::in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	ubxcfg_pkg::out_beat_t out_data;
	logic      cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	ubx_report_tracker reports = new();
	bit calm;
	int sent;

	ubx_config_reply_field_extractor_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic send_beat(input logic [1:0] op, input logic [7:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data.operation <= op;
		in_data.rx_byte <= value;
		do @(posedge clk); while (in_stall);
		reports.note_beat(in_data);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
			input logic [15:0] len, input int body_len, input int tick_pct);
		send_beat(ubxcfg_pkg::OP_BYTE, ubxcfg_pkg::SYNC_FIRST);
		send_beat(ubxcfg_pkg::OP_BYTE, ubxcfg_pkg::SYNC_SECOND);
		send_beat(ubxcfg_pkg::OP_BYTE, cls);
		send_beat(ubxcfg_pkg::OP_BYTE, id);
		send_beat(ubxcfg_pkg::OP_BYTE, len[7:0]);
		send_beat(ubxcfg_pkg::OP_BYTE, len[15:8]);
		for (int k = 0; k < body_len; k++) begin
			if ($urandom_range(1, 100) <= tick_pct)
				send_beat(ubxcfg_pkg::OP_TICK, 8'($urandom_range(0, 255)));
			send_beat(ubxcfg_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic drain_reports();
		in_valid <= 1'b0;
		while (reports.pending_reports.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic set_regs(input logic [15:0] tmo, input logic [7:0] cls,
			input logic [7:0] id, input logic [5:0] offset);
		cfg_we <= 1'b1;
		cfg_index <= ubxcfg_pkg::REG_TIMEOUT_MS;
		cfg_data <= tmo;
		reports.set_reg(ubxcfg_pkg::REG_TIMEOUT_MS, tmo);
		@(negedge clk);
		cfg_index <= ubxcfg_pkg::REG_WANTED_CLASS;
		cfg_data <= {8'h00, cls};
		reports.set_reg(ubxcfg_pkg::REG_WANTED_CLASS, {8'h00, cls});
		@(negedge clk);
		cfg_index <= ubxcfg_pkg::REG_WANTED_ID;
		cfg_data <= {8'h00, id};
		reports.set_reg(ubxcfg_pkg::REG_WANTED_ID, {8'h00, id});
		@(negedge clk);
		cfg_index <= ubxcfg_pkg::REG_CAPTURE_OFFSET;
		cfg_data <= {10'h000, offset};
		reports.set_reg(ubxcfg_pkg::REG_CAPTURE_OFFSET, {10'h000, offset});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap();
			end
			@(posedge clk);
			if (out_valid && !out_stall)
				reports.check_report(out_data);
		end
	end

	initial begin
		#(2 * HALF_PERIOD * RUN_LIMIT_CYCLES);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int r;
		int target;
		int phase_end;
		int need;
		int body;
		logic [15:0] tmo;
		logic [7:0]  cls;
		logic [7:0]  id;
		logic [5:0]  offset;
		logic [15:0] len;

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = ubxcfg_pkg::REG_TIMEOUT_MS;
		cfg_data = '0;
		calm = 1'b0;
		sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_beat(ubxcfg_pkg::OP_BYTE, ubxcfg_pkg::SYNC_FIRST);
		send_beat(ubxcfg_pkg::OP_TICK, 8'hFF);
		send_beat(OP_RESERVED, 8'h00);
		send_beat(ubxcfg_pkg::OP_START, 8'h00);
		send_beat(ubxcfg_pkg::OP_TICK, 8'h00);
		send_beat(ubxcfg_pkg::OP_BYTE, ubxcfg_pkg::SYNC_FIRST);
		send_beat(ubxcfg_pkg::OP_BYTE, ubxcfg_pkg::SYNC_FIRST);
		send_beat(ubxcfg_pkg::OP_BYTE, ubxcfg_pkg::SYNC_SECOND);
		send_frame(ubxcfg_pkg::CLASS_RESET, ubxcfg_pkg::ID_RESET, 16'd1, 3, 0);
		drain_reports();
		set_regs(16'h0000, ubxcfg_pkg::CLASS_RESET, ubxcfg_pkg::ID_RESET,
			ubxcfg_pkg::OFFSET_RESET);
		send_beat(ubxcfg_pkg::OP_START, 8'h00);
		send_beat(ubxcfg_pkg::OP_TICK, 8'h00);
		drain_reports();
		set_regs(ubxcfg_pkg::ELAPSED_MAX, 8'hFF, 8'h00, 6'd0);
		send_beat(ubxcfg_pkg::OP_START, 8'h00);
		send_beat(ubxcfg_pkg::OP_BYTE, ubxcfg_pkg::SYNC_FIRST);
		send_beat(ubxcfg_pkg::OP_START, 8'h00);
		send_frame(8'hFF, 8'h00, 16'd0, 2, 0);

		target = sent + RANDOM_ITEMS;
		while (sent < target) begin
			drain_reports();
			case ($urandom_range(0, 4))
				0: tmo = 16'd1;
				1: tmo = 16'($urandom_range(2, 12));
				2: tmo = 16'($urandom_range(13, 300));
				3: tmo = ubxcfg_pkg::ELAPSED_MAX;
				default: tmo = 16'($urandom_range(0, 65535));
			endcase
			cls = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 3) == 0)
				cls = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			id = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 3) == 0)
				id = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			case ($urandom_range(0, 4))
				0: offset = 6'($urandom_range(0, 1));
				1: offset = 6'd63;
				2: offset = 6'($urandom_range(6, 12));
				default: offset = 6'($urandom_range(0, 63));
			endcase
			set_regs(tmo, cls, id, offset);
			calm = ($urandom_range(0, 3) == 0);
			phase_end = sent + $urandom_range(50, 90);

			while (sent < phase_end && sent < target) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					if ($urandom_range(0, 99) < 85)
						send_beat(ubxcfg_pkg::OP_START, 8'($urandom_range(0, 255)));
					repeat ($urandom_range(0, 2))
						send_beat(ubxcfg_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
					cls = ($urandom_range(0, 4) != 0) ? reports.wanted_class
						: 8'($urandom_range(0, 255));
					id = ($urandom_range(0, 4) != 0) ? reports.wanted_id
						: 8'($urandom_range(0, 255));
					r = $urandom_range(0, 99);
					if (r < 70)
						len = 16'($urandom_range(0, 8));
					else if (r < 90)
						len = 16'($urandom_range(9, 56));
					else
						len = 16'($urandom_range(57, 65535));
					need = (len > 16'd56) ? 60 : int'(len) + 2;
					if (int'(reports.capture_offset) - 5 > need)
						need = int'(reports.capture_offset) - 5;
					r = $urandom_range(0, 99);
					if (r < 10)
						body = $urandom_range(0, need);
					else if (r < 85)
						body = need + $urandom_range(0, 2);
					else
						body = 60;
					if (body > 60)
						body = 60;
					send_frame(cls, id, len, body, calm ? 0 : 8);
				end else if (r < 75) begin
					send_beat(ubxcfg_pkg::OP_START, 8'($urandom_range(0, 255)));
					repeat ($urandom_range(1, 24))
						send_beat(ubxcfg_pkg::OP_TICK, 8'($urandom_range(0, 255)));
				end else begin
					repeat ($urandom_range(1, 8))
						send_beat(2'($urandom_range(ubxcfg_pkg::OP_START, OP_RESERVED)),
							8'($urandom_range(0, 255)));
				end
			end
		end

		drain_reports();
		repeat (8) @(posedge clk);
		if (reports.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
